>>> rtl/mmc_pkg.sv
package mmc_pkg;

  // Fixed field widths
  localparam int SMP_W = 16;
  localparam int CNT_W = 16;
  localparam int CFG_W = 16;
  localparam int TIME_W = 32;
  localparam int CMD_W = 3;
  localparam int CFG_IDX_W = 1;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE = 3'd0,
    CMD_START  = 3'd1,
    CMD_STOP   = 3'd2,
    CMD_CALC   = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SAMPLES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE   = 1'd1;
  localparam logic [CFG_W-1:0] MIN_SAMPLES_RST = 16'd10;
  localparam logic [CFG_W-1:0] MIN_RANGE_RST   = 16'd1;

  // Status codes
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REFUSE = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic signed [SMP_W-1:0] sample_x;
    logic signed [SMP_W-1:0] sample_y;
    logic signed [SMP_W-1:0] sample_z;
    logic [TIME_W-1:0]       sample_time;
  } in_item_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] cal_x;
    logic signed [SMP_W-1:0] cal_y;
    logic signed [SMP_W-1:0] cal_z;
    logic [TIME_W-1:0]       out_time;
    logic                    status;
    logic                    calibrated;
    logic [CNT_W-1:0]        samples_taken;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic exec;
    logic mul;
    logic div_load;
    logic div_store;
    logic commit;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             refuse;
    logic             unity;
    logic             div_done;
    logic             last_axis;
    logic             out_free;
  } ctrl_stat_t;

endpackage

>>> rtl/mmc_div.sv
module mmc_div #(
  parameter int NW = 32,
  parameter int DW = 18
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num;
  logic [DW-1:0] den;
  logic [DW-1:0] rem;
  logic [CW-1:0] cnt;
  logic          busy;

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  // One restoring step: bring down a bit, subtract if it fits
  always_comb begin
    trial = {rem, num[NW-1]};
    diff  = trial - {1'b0, den};
    ge    = (trial >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == CW'(1))) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Shift quotient bits in behind the dividend
  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      den <= divisor;
      rem <= '0;
      cnt <= CW'(NW);
    end else if (busy) begin
      rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
      num <= {num[NW-2:0], ge};
      cnt <= cnt - CW'(1);
    end
  end

  assign quotient = num;

endmodule

>>> rtl/mmc_dp.sv
module mmc_dp #(
  parameter int SCALE_FRAC_BITS = 14
) (
  input  logic                              clk,
  input  logic                              rst,
  input  mmc_pkg::in_item_t                 in_data,
  input  logic                              in_load,
  input  logic                              cfg_we,
  input  logic [mmc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mmc_pkg::CFG_W-1:0]         cfg_data,
  input  mmc_pkg::ctrl_cmd_t                cmd,
  output mmc_pkg::ctrl_stat_t               stat,
  output mmc_pkg::out_item_t                out_data,
  output logic                              out_valid,
  input  logic                              out_ready
);

  localparam int SW  = mmc_pkg::SMP_W;
  localparam int F   = SCALE_FRAC_BITS;
  localparam int SCW = F + 4;
  localparam int DW  = SW + 2;
  localparam int NW  = DW + F;
  localparam int PW  = (SW + 1) + (SCW + 1);
  localparam int PSW = PW - F;
  localparam logic [SCW-1:0] SCALE_ONE = {4'b0001, {F{1'b0}}};
  localparam logic [SCW-1:0] SCALE_TOP = {SCW{1'b1}};
  localparam logic signed [SW-1:0] SMP_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMP_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic [mmc_pkg::CNT_W-1:0] CNT_TOP = {mmc_pkg::CNT_W{1'b1}};
  localparam logic [mmc_pkg::CNT_W-1:0] CNT_ONE = {{(mmc_pkg::CNT_W-1){1'b0}}, 1'b1};
  localparam logic [1:0] LAST_AXIS = 2'd2;

  // Architectural state
  logic [mmc_pkg::CFG_W-1:0] min_samples;
  logic [mmc_pkg::CFG_W-1:0] min_range;
  logic signed [SW-1:0]      offset [3];
  logic [SCW-1:0]            scale [3];
  logic                      cal_flag;
  logic signed [SW-1:0]      amin [3];
  logic signed [SW-1:0]      amax [3];
  logic [mmc_pkg::CNT_W-1:0] total;
  logic                      collecting;

  // Working registers
  mmc_pkg::in_item_t         item;
  logic signed [SW:0]        diff [3];
  logic signed [PW-1:0]      prod [3];
  logic [SW-1:0]             rng [3];
  logic [DW-1:0]             sum;
  logic signed [SW-1:0]      offs_st [3];
  logic [SCW-1:0]            scale_st [3];
  logic [1:0]                ax;
  mmc_pkg::out_item_t        out_q;
  logic                      out_valid_q;

  // Combinational values
  logic signed [SW-1:0]      raw [3];
  logic signed [SW:0]        span [3];
  logic signed [SW:0]        mid [3];
  logic [SW-1:0]             rng_n [3];
  logic signed [SW-1:0]      offs_n [3];
  logic [DW-1:0]             sum_n;
  logic [PSW-1:0]            sh [3];
  logic signed [SW-1:0]      sat [3];
  logic                      unity;
  logic                      div_start;
  logic                      div_done;
  logic [NW-1:0]             quot;
  logic [SCW-1:0]            quot_clamp;
  logic [DW-1:0]             divisor;

  // Next values applied at commit
  logic signed [SW-1:0]      cal_n [3];
  logic signed [SW-1:0]      offset_n [3];
  logic [SCW-1:0]            scale_n [3];
  logic signed [SW-1:0]      amin_n [3];
  logic signed [SW-1:0]      amax_n [3];
  logic                      flag_n;
  logic                      collecting_n;
  logic [mmc_pkg::CNT_W-1:0] total_n;
  logic                      status_n;
  logic                      refuse;

  always_comb begin
    raw[0] = item.sample_x;
    raw[1] = item.sample_y;
    raw[2] = item.sample_z;
  end

  // Ranges, midpoints and range sum from the collected extremes
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      span[i]   = {amax[i][SW-1], amax[i]} - {amin[i][SW-1], amin[i]};
      mid[i]    = {amax[i][SW-1], amax[i]} + {amin[i][SW-1], amin[i]};
      rng_n[i]  = span[i][SW-1:0];
      offs_n[i] = mid[i][SW:1];
    end
    sum_n = {2'b00, rng_n[0]} + {2'b00, rng_n[1]} + {2'b00, rng_n[2]};
  end

  // Floor shift of the product and saturation to sample width
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh[i] = prod[i][PW-1:F];
      if ((&sh[i][PSW-1:SW-1]) || !(|sh[i][PSW-1:SW-1])) begin
        sat[i] = sh[i][SW-1:0];
      end else begin
        sat[i] = sh[i][PSW-1] ? SMP_MIN : SMP_MAX;
      end
    end
  end

  // Scale divider, shared over the three axes
  assign unity     = (rng[ax] == '0) || (rng[ax] < min_range);
  assign div_start = cmd.div_load && !unity;
  assign divisor   = {2'b00, rng[ax]} + {1'b0, rng[ax], 1'b0};
  assign quot_clamp = (|quot[NW-1:SCW]) ? SCALE_TOP : quot[SCW-1:0];

  mmc_div #(
    .NW(NW),
    .DW(DW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend({sum, {F{1'b0}}}),
    .divisor (divisor),
    .done    (div_done),
    .quotient(quot)
  );

  assign refuse = (total < min_samples);

  // Decide the effect of the request on state and result
  always_comb begin
    flag_n       = cal_flag;
    collecting_n = collecting;
    total_n      = total;
    status_n     = mmc_pkg::STATUS_OK;
    for (int i = 0; i < 3; i++) begin
      cal_n[i]    = '0;
      offset_n[i] = offset[i];
      scale_n[i]  = scale[i];
      amin_n[i]   = amin[i];
      amax_n[i]   = amax[i];
    end
    unique case (item.command)
      mmc_pkg::CMD_SAMPLE: begin
        for (int i = 0; i < 3; i++) begin
          cal_n[i] = cal_flag ? sat[i] : raw[i];
          if (collecting) begin
            if (total == '0) begin
              amin_n[i] = raw[i];
              amax_n[i] = raw[i];
            end else begin
              if (raw[i] < amin[i]) amin_n[i] = raw[i];
              if (raw[i] > amax[i]) amax_n[i] = raw[i];
            end
          end
        end
        if (collecting && (total != CNT_TOP)) begin
          total_n = total + CNT_ONE;
        end
      end
      mmc_pkg::CMD_START: begin
        for (int i = 0; i < 3; i++) begin
          amin_n[i] = '0;
          amax_n[i] = '0;
        end
        total_n      = '0;
        collecting_n = 1'b1;
      end
      mmc_pkg::CMD_STOP: begin
        collecting_n = 1'b0;
      end
      mmc_pkg::CMD_CALC: begin
        if (refuse) begin
          status_n = mmc_pkg::STATUS_REFUSE;
        end else begin
          for (int i = 0; i < 3; i++) begin
            offset_n[i] = offs_st[i];
            scale_n[i]  = scale_st[i];
          end
          flag_n = 1'b1;
        end
      end
      mmc_pkg::CMD_CLEAR: begin
        for (int i = 0; i < 3; i++) begin
          offset_n[i] = '0;
          scale_n[i]  = SCALE_ONE;
        end
        flag_n = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_samples <= mmc_pkg::MIN_SAMPLES_RST;
      min_range   <= mmc_pkg::MIN_RANGE_RST;
    end else if (cfg_we) begin
      if (cfg_index == mmc_pkg::REG_MIN_SAMPLES) begin
        min_samples <= cfg_data;
      end else begin
        min_range <= cfg_data;
      end
    end
  end

  // Calibration and collection state, updated at commit
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_flag   <= 1'b0;
      collecting <= 1'b0;
      total      <= '0;
      for (int i = 0; i < 3; i++) begin
        offset[i] <= '0;
        scale[i]  <= SCALE_ONE;
        amin[i]   <= '0;
        amax[i]   <= '0;
      end
    end else if (cmd.commit) begin
      cal_flag   <= flag_n;
      collecting <= collecting_n;
      total      <= total_n;
      for (int i = 0; i < 3; i++) begin
        offset[i] <= offset_n[i];
        scale[i]  <= scale_n[i];
        amin[i]   <= amin_n[i];
        amax[i]   <= amax_n[i];
      end
    end
  end

  // Capture the request when it is accepted
  always_ff @(posedge clk) begin
    if (in_load) begin
      item <= in_data;
    end
  end

  // Stage registers for correction and calculate
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ax  <= '0;
      sum <= sum_n;
      for (int i = 0; i < 3; i++) begin
        diff[i]    <= {raw[i][SW-1], raw[i]} - {offset[i][SW-1], offset[i]};
        rng[i]     <= rng_n[i];
        offs_st[i] <= offs_n[i];
      end
    end else if (cmd.div_load && unity) begin
      scale_st[ax] <= SCALE_ONE;
      ax           <= ax + 2'd1;
    end else if (cmd.div_store) begin
      scale_st[ax] <= quot_clamp;
      ax           <= ax + 2'd1;
    end
    if (cmd.mul) begin
      for (int i = 0; i < 3; i++) begin
        prod[i] <= diff[i] * $signed({1'b0, scale[i]});
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_q.cal_x         <= cal_n[0];
      out_q.cal_y         <= cal_n[1];
      out_q.cal_z         <= cal_n[2];
      out_q.out_time      <= item.sample_time;
      out_q.status        <= status_n;
      out_q.calibrated    <= flag_n;
      out_q.samples_taken <= total_n;
    end
  end

  assign out_data  = out_q;
  assign out_valid = out_valid_q;

  always_comb begin
    stat.op        = item.command;
    stat.refuse    = refuse;
    stat.unity     = unity;
    stat.div_done  = div_done;
    stat.last_axis = (ax == LAST_AXIS);
    stat.out_free  = !out_valid_q || out_ready;
  end

  // Collected extremes stay ordered
  a_minmax_order: assert property (@(posedge clk) disable iff (rst)
    (amin[0] <= amax[0]) && (amin[1] <= amax[1]) && (amin[2] <= amax[2]))
    else $error("axis minimum above maximum");

  // A result appears only through a commit
  a_out_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid_q) |-> $past(cmd.commit))
    else $error("result without commit");

  // A waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid_q && !out_ready) |=> (out_valid_q && $stable(out_q)))
    else $error("waiting result changed or dropped");

endmodule

>>> rtl/mmc_ctrl.sv
module mmc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                in_load,
  input  mmc_pkg::ctrl_stat_t stat,
  output mmc_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_EXEC   = 6'b000010,
    ST_MUL    = 6'b000100,
    ST_DLOAD  = 6'b001000,
    ST_DWAIT  = 6'b010000,
    ST_COMMIT = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);
  assign in_load  = in_valid && in_ready;

  // Sequence each request through its steps
  always_comb begin
    state_next    = state;
    cmd           = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.op == mmc_pkg::CMD_SAMPLE) begin
          state_next = ST_MUL;
        end else if ((stat.op == mmc_pkg::CMD_CALC) && !stat.refuse) begin
          state_next = ST_DLOAD;
        end else begin
          state_next = ST_COMMIT;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_COMMIT;
      end
      ST_DLOAD: begin
        cmd.div_load = 1'b1;
        if (!stat.unity) begin
          state_next = ST_DWAIT;
        end else if (stat.last_axis) begin
          state_next = ST_COMMIT;
        end
      end
      ST_DWAIT: begin
        if (stat.div_done) begin
          cmd.div_store = 1'b1;
          state_next    = stat.last_axis ? ST_COMMIT : ST_DLOAD;
        end
      end
      ST_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Commit never overwrites a result still waiting
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> stat.out_free)
    else $error("commit into occupied output register");

  // Divider finishes only while waiting for it
  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> (state == ST_DWAIT))
    else $error("divider done outside wait state");

  // An accepted request is decoded next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    in_load |=> (state == ST_EXEC))
    else $error("accepted request not decoded");

endmodule

>>> rtl/magnetometer_minmax_calibration.sv
// Min/max magnetometer calibration. Requests carry a command and a three-axis
// sample; every request gives exactly one result. Commands start and stop a
// collection phase that tracks per-axis extremes and a saturating count;
// calculate turns them into floored-midpoint offsets and Q4.SCALE_FRAC_BITS
// scales; clear drops back to pass-through. One request is in work at a time.
// A sample's result is registered through subtract, multiply, then saturate
// and commit steps, and the next request can be taken in the cycle after the
// commit. Start, stop, clear and a refused calculate go straight from decode
// to commit. A calculate that runs uses the shared restoring divider, which
// produces one quotient bit per cycle for each axis in turn, with a load and
// a store step per axis; an axis below the range threshold skips its divide.
// The next request is taken while a result waits in the output register; it
// then holds at its commit step until the result side takes the waiting one.
module magnetometer_minmax_calibration #(
  parameter int SCALE_FRAC_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mmc_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mmc_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [mmc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mmc_pkg::CFG_W-1:0]     cfg_data
);

  mmc_pkg::ctrl_cmd_t  cmd;
  mmc_pkg::ctrl_stat_t stat;
  logic                in_load;

  mmc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_load (in_load),
    .stat    (stat),
    .cmd     (cmd)
  );

  mmc_dp #(
    .SCALE_FRAC_BITS(SCALE_FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .in_load  (in_load),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data),
    .out_valid(out_valid),
    .out_ready(out_ready)
  );

endmodule

>>> verif/magnetometer_minmax_calibration_tb.sv
module testbench;

  localparam int SMP_W = mmc_pkg::SMP_W;
  localparam int CNT_W = mmc_pkg::CNT_W;
  localparam int CFG_W = mmc_pkg::CFG_W;
  localparam int TIME_W = mmc_pkg::TIME_W;
  localparam int CMD_W = mmc_pkg::CMD_W;
  localparam int CFG_IDX_W = mmc_pkg::CFG_IDX_W;

  localparam int SCALE_FRAC = 14;
  localparam int GAIN_W = SCALE_FRAC + 4;
  localparam longint SCALE_ONE = longint'(1) << SCALE_FRAC;
  localparam longint SCALE_TOP = (longint'(1) << (SCALE_FRAC + 4)) - 1;
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(SCALE_ONE);
  localparam logic [CNT_W-1:0] CNT_ONE = {{(CNT_W-1){1'b0}}, 1'b1};
  localparam longint SMP_TOP = 32767;
  localparam longint SMP_BOTTOM = -32768;
  localparam int STALL_LIMIT = 4000;
  localparam int MAX_PRINTS = 40;
  localparam int LONG_RUN = 150;

  // Command codes the block does not define; it must ignore them
  localparam logic [CMD_W-1:0] CMD_UNUSED_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  mmc_pkg::in_item_t in_data;
  logic out_valid;
  logic out_ready;
  mmc_pkg::out_item_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  magnetometer_minmax_calibration #(
    .SCALE_FRAC_BITS(SCALE_FRAC)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Calibration state as the block should hold it
  logic [CFG_W-1:0] need_samples = mmc_pkg::MIN_SAMPLES_RST;
  logic [CFG_W-1:0] need_range = mmc_pkg::MIN_RANGE_RST;
  logic signed [SMP_W-1:0] axis_off [3] = '{default: '0};
  logic [GAIN_W-1:0] axis_gain [3] = '{default: GAIN_ONE};
  logic signed [SMP_W-1:0] axis_lo [3] = '{default: '0};
  logic signed [SMP_W-1:0] axis_hi [3] = '{default: '0};
  logic [CNT_W-1:0] taken = '0;
  bit cal_active = 0;
  bit gathering = 0;

  mmc_pkg::out_item_t readings_due [$];
  int error_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int stall_cycles = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Work out the result of one request and advance the calibration state
  function automatic mmc_pkg::out_item_t calibrate_reading(mmc_pkg::in_item_t req);
    mmc_pkg::out_item_t res;
    longint raw [3];
    longint corr [3];
    longint spans [3];
    longint span_sum;
    longint prod;
    longint quot;
    res = '0;
    raw[0] = longint'($signed(req.sample_x));
    raw[1] = longint'($signed(req.sample_y));
    raw[2] = longint'($signed(req.sample_z));
    corr = '{0, 0, 0};
    case (req.command)
      mmc_pkg::CMD_SAMPLE: begin
        // correct with the calibration in force before this sample
        for (int i = 0; i < 3; i++) begin
          if (cal_active) begin
            prod = (raw[i] - longint'(axis_off[i])) * longint'(axis_gain[i]);
            quot = prod >>> SCALE_FRAC;
            if (quot > SMP_TOP) quot = SMP_TOP;
            else if (quot < SMP_BOTTOM) quot = SMP_BOTTOM;
            corr[i] = quot;
          end else begin
            corr[i] = raw[i];
          end
        end
        if (gathering) begin
          for (int i = 0; i < 3; i++) begin
            if (taken == 0) begin
              axis_lo[i] = SMP_W'(raw[i]);
              axis_hi[i] = SMP_W'(raw[i]);
            end else begin
              if (raw[i] < longint'(axis_lo[i])) axis_lo[i] = SMP_W'(raw[i]);
              if (raw[i] > longint'(axis_hi[i])) axis_hi[i] = SMP_W'(raw[i]);
            end
          end
          if (taken != '1) taken = taken + CNT_ONE;
        end
      end
      mmc_pkg::CMD_START: begin
        axis_lo = '{default: '0};
        axis_hi = '{default: '0};
        taken = '0;
        gathering = 1;
      end
      mmc_pkg::CMD_STOP: gathering = 0;
      mmc_pkg::CMD_CALC: begin
        if (taken < need_samples) begin
          res.status = mmc_pkg::STATUS_REFUSE;
        end else begin
          span_sum = 0;
          for (int i = 0; i < 3; i++) begin
            spans[i] = longint'(axis_hi[i]) - longint'(axis_lo[i]);
            span_sum += spans[i];
            axis_off[i] = SMP_W'((longint'(axis_lo[i]) + longint'(axis_hi[i])) >>> 1);
          end
          for (int i = 0; i < 3; i++) begin
            if (spans[i] == 0 || spans[i] < longint'(need_range)) begin
              axis_gain[i] = GAIN_ONE;
            end else begin
              quot = (span_sum << SCALE_FRAC) / (3 * spans[i]);
              axis_gain[i] = GAIN_W'((quot > SCALE_TOP) ? SCALE_TOP : quot);
            end
          end
          cal_active = 1;
        end
      end
      mmc_pkg::CMD_CLEAR: begin
        axis_off = '{default: '0};
        axis_gain = '{default: GAIN_ONE};
        cal_active = 0;
      end
      default: ;
    endcase
    res.cal_x = corr[0][SMP_W-1:0];
    res.cal_y = corr[1][SMP_W-1:0];
    res.cal_z = corr[2][SMP_W-1:0];
    res.out_time = req.sample_time;
    res.calibrated = cal_active;
    res.samples_taken = taken;
    return res;
  endfunction

  // Drive one request and record its expected result once accepted
  task automatic send_req(input logic [CMD_W-1:0] cmd, input logic [SMP_W-1:0] x,
                          input logic [SMP_W-1:0] y, input logic [SMP_W-1:0] z,
                          input logic [TIME_W-1:0] stamp);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_data.command = cmd;
    in_data.sample_x = x;
    in_data.sample_y = y;
    in_data.sample_z = z;
    in_data.sample_time = stamp;
    in_valid = 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    readings_due.push_back(calibrate_reading(in_data));
  endtask

  function automatic logic [SMP_W-1:0] rand_smp();
    logic [31:0] r;
    r = $urandom();
    return r[SMP_W-1:0];
  endfunction

  task automatic send_cmd(input logic [CMD_W-1:0] cmd);
    send_req(cmd, rand_smp(), rand_smp(), rand_smp(), $urandom());
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid = 0;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 0;
    if (idx == mmc_pkg::REG_MIN_SAMPLES) need_samples = value;
    else need_range = value;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    drain_results();
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  function automatic int pick_spread();
    case ($urandom_range(4))
      0: return 0;
      1: return $urandom_range(1, 8);
      2: return $urandom_range(9, 600);
      3: return $urandom_range(601, 20000);
      default: return 65535;
    endcase
  endfunction

  function automatic logic [SMP_W-1:0] axis_near(input int centre, input int spread);
    int v;
    v = centre + int'($urandom_range(2 * spread)) - spread;
    if (v > SMP_TOP) v = SMP_TOP;
    if (v < SMP_BOTTOM) v = SMP_BOTTOM;
    return v[SMP_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("mismatch on %s: got %0h, expected %0h", what, got, want);
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Compare each returned result with the oldest pending expectation
  always @(posedge clk) begin
    mmc_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (readings_due.size() == 0) begin
        report_mismatch("result with nothing pending", out_data.out_time, 0);
      end else begin
        want = readings_due.pop_front();
        check_field("cal_x", 32'(out_data.cal_x), 32'(want.cal_x));
        check_field("cal_y", 32'(out_data.cal_y), 32'(want.cal_y));
        check_field("cal_z", 32'(out_data.cal_z), 32'(want.cal_z));
        check_field("out_time", out_data.out_time, want.out_time);
        check_field("status", 32'(out_data.status), 32'(want.status));
        check_field("calibrated", 32'(out_data.calibrated), 32'(want.calibrated));
        check_field("samples_taken", 32'(out_data.samples_taken),
                    32'(want.samples_taken));
      end
    end
  end

  // Stall the result side at random, or hold it off entirely for a stretch
  initial begin
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Abort if nothing moves on either side for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("magnetometer_minmax_calibration verification failed");
        $finish;
      end
    end
  end

  // Extremes, unknown commands, refused and accepted calculate, clear
  task automatic test_directed();
    write_reg(mmc_pkg::REG_MIN_SAMPLES, 16'd3);
    send_req(mmc_pkg::CMD_SAMPLE, 16'h8000, 16'h7fff, 16'h0000, 32'h0000_0000);
    send_req(mmc_pkg::CMD_SAMPLE, 16'h7fff, 16'h8000, 16'hffff, 32'hffff_ffff);
    send_cmd(CMD_UNUSED_5);
    send_cmd(CMD_UNUSED_7);
    send_cmd(mmc_pkg::CMD_STOP);
    send_cmd(mmc_pkg::CMD_CALC);
    send_cmd(mmc_pkg::CMD_CLEAR);
    send_cmd(mmc_pkg::CMD_START);
    // x spans the full range, y has zero range, z range one overflows its scale
    send_req(mmc_pkg::CMD_SAMPLE, 16'h8000, 16'd5, 16'd0, $urandom());
    send_req(mmc_pkg::CMD_SAMPLE, 16'h7fff, 16'd5, 16'd1, $urandom());
    send_cmd(mmc_pkg::CMD_CALC);
    send_req(mmc_pkg::CMD_SAMPLE, 16'd0, 16'd5, 16'd0, $urandom());
    send_cmd(mmc_pkg::CMD_CALC);
    send_req(mmc_pkg::CMD_SAMPLE, 16'h7fff, 16'h8000, 16'd1, $urandom());
    send_req(mmc_pkg::CMD_SAMPLE, 16'h8000, 16'h7fff, 16'h8000, $urandom());
    send_cmd(mmc_pkg::CMD_STOP);
    send_req(mmc_pkg::CMD_SAMPLE, 16'd100, 16'd100, 16'd100, $urandom());
    send_cmd(mmc_pkg::CMD_CLEAR);
    send_req(mmc_pkg::CMD_SAMPLE, 16'd1, 16'd2, 16'd3, $urandom());
    send_cmd(CMD_UNUSED_6);
  endtask

  // Register extremes: calculate on no samples, full and zero thresholds
  task automatic test_config_extremes();
    write_reg(mmc_pkg::REG_MIN_SAMPLES, 16'd0);
    write_reg(mmc_pkg::REG_MIN_RANGE, 16'hffff);
    send_cmd(mmc_pkg::CMD_START);
    send_cmd(mmc_pkg::CMD_CALC);
    send_req(mmc_pkg::CMD_SAMPLE, rand_smp(), rand_smp(), rand_smp(), $urandom());
    send_req(mmc_pkg::CMD_SAMPLE, 16'h8000, 16'd40, 16'hffc0, $urandom());
    send_req(mmc_pkg::CMD_SAMPLE, 16'h7fff, 16'hffd8, 16'd64, $urandom());
    send_cmd(mmc_pkg::CMD_CALC);
    send_req(mmc_pkg::CMD_SAMPLE, rand_smp(), rand_smp(), rand_smp(), $urandom());
    write_reg(mmc_pkg::REG_MIN_RANGE, 16'd0);
    send_cmd(mmc_pkg::CMD_START);
    send_req(mmc_pkg::CMD_SAMPLE, 16'd7, 16'hfff9, 16'd0, $urandom());
    send_req(mmc_pkg::CMD_SAMPLE, 16'd7, 16'hfff9, 16'd0, $urandom());
    send_cmd(mmc_pkg::CMD_CALC);
    send_req(mmc_pkg::CMD_SAMPLE, rand_smp(), rand_smp(), rand_smp(), $urandom());
    send_cmd(mmc_pkg::CMD_CLEAR);
  endtask

  // Hold off the result side long enough that the input stalls
  task automatic test_backpressure();
    set_idling(0, 0);
    @(posedge clk);
    hold_left = 150;
    repeat (20)
      send_req(mmc_pkg::CMD_SAMPLE, rand_smp(), rand_smp(), rand_smp(), $urandom());
  endtask

  // Long collection session; extremes must keep tracking, threshold at the edge
  task automatic test_long_session();
    int centre;
    set_idling(0, 0);
    write_reg(mmc_pkg::REG_MIN_SAMPLES, CFG_W'(LONG_RUN + 1));
    write_reg(mmc_pkg::REG_MIN_RANGE, 16'd1);
    centre = $urandom_range(2000) - 1000;
    send_cmd(mmc_pkg::CMD_START);
    repeat (LONG_RUN)
      send_req(mmc_pkg::CMD_SAMPLE, axis_near(centre, 300), axis_near(-centre, 50),
               axis_near(centre, 1000), $urandom());
    send_cmd(mmc_pkg::CMD_CALC);
    send_req(mmc_pkg::CMD_SAMPLE, axis_near(centre, 300), axis_near(0, 50), 16'd0,
             $urandom());
    send_cmd(mmc_pkg::CMD_CALC);
    send_req(mmc_pkg::CMD_SAMPLE, 16'h8000, 16'h7fff, 16'h8000, $urandom());
    send_req(mmc_pkg::CMD_SAMPLE, 16'h7fff, 16'h8000, 16'h7fff, $urandom());
    send_cmd(mmc_pkg::CMD_CALC);
    send_req(mmc_pkg::CMD_SAMPLE, rand_smp(), rand_smp(), rand_smp(), $urandom());
    send_cmd(mmc_pkg::CMD_CLEAR);
    send_cmd(mmc_pkg::CMD_STOP);
  endtask

  // Mostly whole collect/calculate sessions with random content, some noise
  task automatic test_random_traffic(input int quota);
    int sent;
    int n_pts;
    int n_post;
    int centre [3];
    int spread [3];
    logic [CMD_W-1:0] cmd;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(99) < 80) begin
        for (int a = 0; a < 3; a++) begin
          centre[a] = int'($urandom_range(65535)) - 32768;
          spread[a] = pick_spread();
        end
        send_cmd(mmc_pkg::CMD_START);
        n_pts = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 24);
        repeat (n_pts)
          send_req(mmc_pkg::CMD_SAMPLE, axis_near(centre[0], spread[0]),
                   axis_near(centre[1], spread[1]),
                   axis_near(centre[2], spread[2]), $urandom());
        if ($urandom_range(1)) send_cmd(mmc_pkg::CMD_STOP);
        send_cmd(mmc_pkg::CMD_CALC);
        n_post = $urandom_range(1, 8);
        repeat (n_post)
          send_req(mmc_pkg::CMD_SAMPLE, axis_near(centre[0], 4 * spread[0] + 16),
                   axis_near(centre[1], 4 * spread[1] + 16),
                   axis_near(centre[2], 4 * spread[2] + 16), $urandom());
        sent += n_pts + n_post + 2;
        if ($urandom_range(2) == 0) begin
          send_cmd(mmc_pkg::CMD_CLEAR);
          sent++;
        end
      end else begin
        cmd = CMD_W'($urandom_range(7));
        send_cmd(cmd);
        sent++;
      end
    end
  endtask

  initial begin
    rst = 1;
    in_valid = 0;
    in_data = '0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;

    test_directed();
    test_config_extremes();
    test_backpressure();
    test_long_session();

    set_idling(0, 0);
    write_reg(mmc_pkg::REG_MIN_SAMPLES, 16'd10);
    write_reg(mmc_pkg::REG_MIN_RANGE, 16'd1);
    test_random_traffic(250);

    set_idling(47, 0);
    write_reg(mmc_pkg::REG_MIN_SAMPLES, 16'd0);
    write_reg(mmc_pkg::REG_MIN_RANGE, 16'd0);
    test_random_traffic(250);

    set_idling(0, 47);
    write_reg(mmc_pkg::REG_MIN_SAMPLES, 16'd40);
    write_reg(mmc_pkg::REG_MIN_RANGE, 16'hffff);
    test_random_traffic(250);

    set_idling(37, 37);
    write_reg(mmc_pkg::REG_MIN_SAMPLES, 16'd6);
    write_reg(mmc_pkg::REG_MIN_RANGE, 16'd300);
    test_random_traffic(250);

    // Let the last results drain, then a short quiet tail
    drain_results();
    repeat (20) @(posedge clk);
    if (error_count == 0 && readings_due.size() == 0) begin
      $display("magnetometer_minmax_calibration verification clean");
    end else begin
      $display("magnetometer_minmax_calibration verification failed");
    end
    $finish;
  end

endmodule

>>> magnetometer_minmax_calibration.f
rtl/mmc_pkg.sv
rtl/mmc_div.sv
rtl/mmc_dp.sv
rtl/mmc_ctrl.sv
rtl/magnetometer_minmax_calibration.sv
verif/magnetometer_minmax_calibration_tb.sv
